// ===== hdl/kqs_pkg.sv =====
package kqs_pkg;

  localparam int unsigned DepthDefault   = 64;
  localparam int unsigned KeyBitsDefault = 32;
  localparam int unsigned TagBitsDefault = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;   // input port open
    logic rd_piv;    // read key at hi
    logic cap_piv;   // capture pivot, set i = lo, j = hi
    logic rd_i;      // read key at i
    logic cap_i;     // capture item at i
    logic inc_i;     // i = i + 1
    logic dec_j;     // j = j - 1
    logic rd_j;      // read key at j
    logic cap_j;     // capture item at j
    logic wr_sw1;    // write item j at i
    logic wr_sw2;    // write item i at j
    logic wr_fin1;   // write pivot at i
    logic wr_fin2;   // write item i at hi
    logic push1;     // push upper range
    logic push2;     // push lower range
    logic pop_rd;    // read stack top
    logic pop_ld;    // load lo and hi from stack
    logic emit_rd;   // read item at k
    logic emit_ld;   // load output register, advance k
  } kqs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close_now; // current input closes the set
    logic count_nz;  // more than one item in the set
    logic i_lt_hi;
    logic ahead;     // read key goes before pivot
    logic j_gt_i;
    logic after;     // read key goes after pivot
    logic i_lt_j;
    logic i_ne_hi;
    logic top_zero;  // range stack empty
    logic out_free;  // output register can take an item
    logic k_last;    // k is the last sorted position
  } kqs_stat_t;

endpackage

// ===== hdl/kqs_ctrl.sv =====
module kqs_ctrl import kqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  kqs_stat_t stat_i,
  output kqs_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    StLoad, StPivRd, StPiv, StLsChk, StLsEv, StRsDec, StRsChk, StRsEv,
    StDecide, StSw1, StSw2, StFin1, StFin2, StPush1, StPush2, StPop,
    StPopLd, StEmitRd, StEmitLd
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_valid_i && stat_i.close_now) begin
          state_d = stat_i.count_nz ? StPivRd : StEmitRd;
        end
      end
      StPivRd:  state_d = StPiv;
      StPiv:    state_d = StLsChk;
      StLsChk:  state_d = stat_i.i_lt_hi ? StLsEv : StRsDec;
      StLsEv:   state_d = stat_i.ahead ? StLsChk : StRsDec;
      StRsDec:  state_d = StRsChk;
      StRsChk:  state_d = stat_i.j_gt_i ? StRsEv : StDecide;
      StRsEv:   state_d = stat_i.after ? StRsDec : StDecide;
      StDecide: begin
        if (stat_i.i_lt_j) begin
          state_d = StSw1;
        end else begin
          state_d = stat_i.i_ne_hi ? StFin1 : StPush1;
        end
      end
      StSw1:    state_d = StSw2;
      StSw2:    state_d = StLsChk;
      StFin1:   state_d = StFin2;
      StFin2:   state_d = StPush1;
      StPush1:  state_d = StPush2;
      StPush2:  state_d = StPop;
      StPop:    state_d = stat_i.top_zero ? StEmitRd : StPopLd;
      StPopLd:  state_d = StPivRd;
      StEmitRd: state_d = StEmitLd;
      StEmitLd: begin
        if (stat_i.out_free) begin
          state_d = stat_i.k_last ? StLoad : StEmitRd;
        end
      end
      default:  state_d = StLoad;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.take_in = (state_q == StLoad);
    cmd_o.rd_piv  = (state_q == StPivRd);
    cmd_o.cap_piv = (state_q == StPiv);
    cmd_o.rd_i    = (state_q == StLsChk) && stat_i.i_lt_hi;
    cmd_o.cap_i   = (state_q == StLsEv);
    cmd_o.inc_i   = ((state_q == StLsEv) && stat_i.ahead) || (state_q == StSw2);
    cmd_o.dec_j   = (state_q == StRsDec);
    cmd_o.rd_j    = (state_q == StRsChk) && stat_i.j_gt_i;
    cmd_o.cap_j   = (state_q == StRsEv);
    cmd_o.wr_sw1  = (state_q == StSw1);
    cmd_o.wr_sw2  = (state_q == StSw2);
    cmd_o.wr_fin1 = (state_q == StFin1);
    cmd_o.wr_fin2 = (state_q == StFin2);
    cmd_o.push1   = (state_q == StPush1);
    cmd_o.push2   = (state_q == StPush2);
    cmd_o.pop_rd  = (state_q == StPop) && !stat_i.top_zero;
    cmd_o.pop_ld  = (state_q == StPopLd);
    cmd_o.emit_rd = (state_q == StEmitRd);
    cmd_o.emit_ld = (state_q == StEmitLd) && stat_i.out_free;
  end

endmodule

// ===== hdl/kqs_dp.sv =====
module kqs_dp import kqs_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault,
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kqs_cmd_t            cmd_i,
  output kqs_stat_t           stat_o,
  input  logic                in_valid_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_descending_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [KEY_BITS-1:0] sorted_key_o,
  output logic [TAG_BITS-1:0] sorted_tag_o,
  output logic                final_res_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned MW = KEY_BITS + TAG_BITS;
  localparam int unsigned SW = 2 * IW;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [IW:0]   DepthW  = (IW+1)'(DEPTH);

  logic [MW-1:0] item_mem [DEPTH];
  logic [SW-1:0] stack_mem [DEPTH];

  logic [MW-1:0] rd_data_q;
  logic [SW-1:0] st_data_q;
  logic          desc_q;
  logic [IW-1:0] count_q, nlast_q, lo_q, hi_q, i_q, j_q, k_q;
  logic [IW:0]   top_q;
  logic [KEY_BITS-1:0] piv_key_q, ki_q, kj_q;
  logic [TAG_BITS-1:0] piv_tag_q, ti_q, tj_q;
  logic          out_valid_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic          out_final_q;

  logic          accept;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic [IW:0]   i_ext, lo_ext, hi_ext;
  logic          push1_ok, push2_ok;

  assign accept = cmd_i.take_in && in_valid_i;
  assign rd_key = rd_data_q[MW-1:TAG_BITS];
  assign rd_tag = rd_data_q[TAG_BITS-1:0];
  assign i_ext  = {1'b0, i_q};
  assign lo_ext = {1'b0, lo_q};
  assign hi_ext = {1'b0, hi_q};

  assign push1_ok = (hi_ext > i_ext + 1'b1) && (top_q < DepthW);
  assign push2_ok = (i_ext > lo_ext + 1'b1) && (top_q < DepthW);

  // Status back to the controller
  always_comb begin
    stat_o.close_now = last_i || (count_q == LastIdx);
    stat_o.count_nz  = (count_q != '0);
    stat_o.i_lt_hi   = (i_q < hi_q);
    stat_o.ahead     = desc_q ? (rd_key > piv_key_q) : (rd_key < piv_key_q);
    stat_o.j_gt_i    = (j_q > i_q);
    stat_o.after     = desc_q ? (rd_key < piv_key_q) : (rd_key > piv_key_q);
    stat_o.i_lt_j    = (i_q < j_q);
    stat_o.i_ne_hi   = (i_q != hi_q);
    stat_o.top_zero  = (top_q == '0);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
    stat_o.k_last    = (k_q == nlast_q);
  end

  // Select item memory ports
  always_comb begin
    rd_en   = cmd_i.rd_piv || cmd_i.rd_i || cmd_i.rd_j || cmd_i.emit_rd;
    rd_addr = k_q;
    if (cmd_i.rd_piv) begin
      rd_addr = hi_q;
    end else if (cmd_i.rd_i) begin
      rd_addr = i_q;
    end else if (cmd_i.rd_j) begin
      rd_addr = j_q;
    end
    wr_en   = accept || cmd_i.wr_sw1 || cmd_i.wr_sw2 || cmd_i.wr_fin1 || cmd_i.wr_fin2;
    wr_addr = count_q;
    wr_data = {key_i, tag_i};
    if (cmd_i.wr_sw1) begin
      wr_addr = i_q;
      wr_data = {kj_q, tj_q};
    end else if (cmd_i.wr_sw2) begin
      wr_addr = j_q;
      wr_data = {ki_q, ti_q};
    end else if (cmd_i.wr_fin1) begin
      wr_addr = i_q;
      wr_data = {piv_key_q, piv_tag_q};
    end else if (cmd_i.wr_fin2) begin
      wr_addr = hi_q;
      wr_data = {ki_q, ti_q};
    end
  end

  // Item memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      item_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= item_mem[rd_addr];
    end
  end

  // Range stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push1 && push1_ok) begin
      stack_mem[top_q[IW-1:0]] <= {i_q + 1'b1, hi_q};
    end else if (cmd_i.push2 && push2_ok) begin
      stack_mem[top_q[IW-1:0]] <= {lo_q, i_q - 1'b1};
    end
    if (cmd_i.pop_rd) begin
      st_data_q <= stack_mem[top_q[IW-1:0] - 1'b1];
    end
  end

  // Item and pivot capture registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_piv) begin
      piv_key_q <= rd_key;
      piv_tag_q <= rd_tag;
    end
    if (cmd_i.cap_i) begin
      ki_q <= rd_key;
      ti_q <= rd_tag;
    end
    if (cmd_i.cap_j) begin
      kj_q <= rd_key;
      tj_q <= rd_tag;
    end
  end

  // Index registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= 1'b0;
      count_q <= '0;
      nlast_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      top_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        desc_q <= cfg_descending_i;
      end
      if (accept) begin
        if (stat_o.close_now) begin
          count_q <= '0;
          nlast_q <= count_q;
          lo_q    <= '0;
          hi_q    <= count_q;
          top_q   <= '0;
          k_q     <= '0;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.cap_piv) begin
        i_q <= lo_q;
        j_q <= hi_q;
      end
      if (cmd_i.inc_i) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.dec_j) begin
        j_q <= j_q - 1'b1;
      end
      if ((cmd_i.push1 && push1_ok) || (cmd_i.push2 && push2_ok)) begin
        top_q <= top_q + 1'b1;
      end else if (cmd_i.pop_rd) begin
        top_q <= top_q - 1'b1;
      end
      if (cmd_i.pop_ld) begin
        lo_q <= st_data_q[SW-1:IW];
        hi_q <= st_data_q[IW-1:0];
      end
      if (cmd_i.emit_ld) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_key_q   <= rd_key;
      out_tag_q   <= rd_tag;
      out_final_q <= stat_o.k_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sorted_key_o = out_key_q;
  assign sorted_tag_o = out_tag_q;
  assign final_res_o  = out_final_q;

endmodule

// ===== hdl/keyed_quicksort_engine_core.sv =====
// Keyed quicksort engine. Collects (key, tag) transactions until one with
// last set arrives or DEPTH are held, then sorts them in place by key with
// quicksort (last element as pivot, two inward scans, swap while the scans
// have not crossed), ascending or descending per the descending register,
// and emits the set in order with final_res on the last item. Input is
// stalled from the closing transaction until the last sorted item has been
// loaded into the output register; loading accepts one transaction per
// cycle. Every key compare goes through the single item memory read port
// with registered data, so the left scan reads and then compares each
// element, the right scan steps j, reads and then compares, a swap decides
// and then writes both items, and each partition adds a pivot fetch, pivot
// placement and range stack work. Already ordered input is the worst case
// for sort time; output stalls add to the emit time.
module keyed_quicksort_engine_core import kqs_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault,
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_descending_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KEY_BITS-1:0] sorted_key_o,
  output logic [TAG_BITS-1:0] sorted_tag_o,
  output logic                final_res_o
);

  kqs_cmd_t  cmd;
  kqs_stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !cmd.take_in;

  kqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kqs_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_valid_i       (in_valid_i),
    .key_i            (key_i),
    .tag_i            (tag_i),
    .last_i           (last_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_descending_i (cfg_descending_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .sorted_key_o     (sorted_key_o),
    .sorted_tag_o     (sorted_tag_o),
    .final_res_o      (final_res_o)
  );

endmodule

// ===== hdl/kqs_checker.sv =====
module kqs_checker import kqs_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBitsDefault,
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                last_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [KEY_BITS-1:0] sorted_key_o,
  input logic [TAG_BITS-1:0] sorted_tag_o,
  input logic                final_res_o
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_key_o)
      && $stable(sorted_tag_o) && $stable(final_res_o))
    else $error("stalled output transaction changed");

  // Input opens only once every item but the final one has left
  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> final_res_o)
    else $error("input open while a set is still draining");

  // Closing transaction stops the input
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after set closed");

endmodule

bind keyed_quicksort_engine_core kqs_checker #(
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_kqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sorted_key_o (sorted_key_o),
  .sorted_tag_o (sorted_tag_o),
  .final_res_o  (final_res_o)
);
